/* rtl/bounded_history_table_core_macros.svh */
// ----------------------------------------------------------------------------
// bounded history table assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BOUNDED_HISTORY_TABLE_CORE_MACROS_SVH
`define BOUNDED_HISTORY_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define BHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bht_pkg.sv */
// ----------------------------------------------------------------------------
// bht_pkg
// types and constants shared by the bounded history table
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned LIM_W       = 5;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

  typedef enum logic [3:0] {
    OP_SERIAL      = 4'd0,
    OP_APPEND      = 4'd1,
    OP_APPEND_UNIQ = 4'd2,
    OP_EXISTS      = 4'd3,
    OP_COUNT       = 4'd4,
    OP_REM_ALL     = 4'd5,
    OP_REM_FIRST   = 4'd6,
    OP_REM_LAST    = 4'd7,
    OP_CLEAR       = 4'd8
  } bht_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT
  } bht_state_e;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] value;
  } bht_req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] result_value;
    logic [FILL_W-1:0] fill_count;
  } bht_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } bht_ram_req_t;

endpackage

`default_nettype wire

/* rtl/bht_ram.sv */
// ----------------------------------------------------------------------------
// bht_ram
// history store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bht_ram (
  input  wire logic                        clk_i,
  input  wire bht_pkg::bht_ram_req_t       req_i,
  output logic [bht_pkg::DATA_W-1:0]       rdata_o
);
  import bht_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/bht_ctrl.sv */
// ----------------------------------------------------------------------------
// bht_ctrl
// request sequencer: scan pass for searches, compaction pass for removes and
// for appends into a full table, serial counter and fill count
// ----------------------------------------------------------------------------
`default_nettype none

module bht_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire bht_pkg::bht_req_t             req_i,
  input  wire logic [bht_pkg::CNT_W-1:0]     limit_i,
  output logic                               busy_o,
  output logic                               done_o,
  output bht_pkg::bht_rsp_t                  rsp_o,
  output bht_pkg::bht_ram_req_t              ram_req_o,
  input  wire logic [bht_pkg::DATA_W-1:0]    ram_rdata_i
);
  import bht_pkg::*;

  bht_state_e        state_q, state_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [DATA_W-1:0] serial_q, serial_d;
  logic [3:0]        op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  wr_idx_q, wr_idx_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] tag_q, tag_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] first_q, first_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic              done_q, done_d;
  bht_rsp_t          rsp_q, rsp_d;
  logic              match;
  logic              keep;
  logic              walk_end;

  assign match    = (ram_rdata_i == val_q);
  assign walk_end = (rd_idx_q == held_q) && !pend_q;

  always_comb begin
    case (op_q)
      OP_APPEND, OP_APPEND_UNIQ: keep = (tag_q != '0) && (CNT_W'(tag_q) < limit_i);
      OP_REM_ALL:                keep = !match;
      OP_REM_FIRST:              keep = (tag_q != first_q);
      default:                   keep = (tag_q != last_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      held_q   <= '0;
      serial_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      serial_q <= serial_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    tag_q    <= tag_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    last_q   <= last_d;
    rsp_q    <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    serial_d  = serial_q;
    op_d      = op_q;
    val_d     = val_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    pend_d    = 1'b0;
    tag_d     = tag_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    last_d    = last_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = wr_idx_q[ADDR_W-1:0];
    ram_req_o.wdata = ram_rdata_i;
    ram_req_o.raddr = rd_idx_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = req_i.op;
          val_d    = req_i.value;
          cnt_d    = '0;
          rd_idx_d = '0;
          wr_idx_d = '0;
          done_d   = 1'b1;
          rsp_d.hit          = 1'b0;
          rsp_d.result_value = '0;
          rsp_d.fill_count   = FILL_W'(held_q);
          case (req_i.op)
            OP_SERIAL: begin
              serial_d           = serial_q + 1'b1;
              rsp_d.result_value = serial_q + 1'b1;
            end
            OP_CLEAR: begin
              held_d           = '0;
              serial_d         = '0;
              rsp_d.fill_count = '0;
            end
            OP_APPEND: begin
              if (limit_i != '0) begin
                if (held_q < limit_i) begin
                  ram_req_o.we     = 1'b1;
                  ram_req_o.waddr  = held_q[ADDR_W-1:0];
                  ram_req_o.wdata  = req_i.value;
                  held_d           = held_q + 1'b1;
                  rsp_d.fill_count = FILL_W'(held_q + 1'b1);
                end else begin
                  // full: drop the oldest while shifting down
                  done_d   = 1'b0;
                  state_d  = ST_COMPACT;
                  rd_idx_d = CNT_W'(1);
                end
              end
            end
            OP_APPEND_UNIQ, OP_EXISTS, OP_COUNT, OP_REM_ALL, OP_REM_FIRST,
            OP_REM_LAST: begin
              if (limit_i != '0) begin
                done_d  = 1'b0;
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_idx_q < held_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
          tag_d    = rd_idx_q[ADDR_W-1:0];
        end
        if (pend_q && match) begin
          cnt_d  = cnt_q + 1'b1;
          last_d = tag_q;
          if (cnt_q == '0) begin
            first_d = tag_q;
          end
        end
        if (walk_end) begin
          done_d             = 1'b1;
          state_d            = ST_IDLE;
          rsp_d.hit          = 1'b0;
          rsp_d.result_value = '0;
          rsp_d.fill_count   = FILL_W'(held_q);
          case (op_q)
            OP_APPEND_UNIQ: begin
              if (cnt_q == '0) begin
                rsp_d.hit = 1'b1;
                if (held_q < limit_i) begin
                  ram_req_o.we     = 1'b1;
                  ram_req_o.waddr  = held_q[ADDR_W-1:0];
                  ram_req_o.wdata  = val_q;
                  held_d           = held_q + 1'b1;
                  rsp_d.fill_count = FILL_W'(held_q + 1'b1);
                end else begin
                  done_d   = 1'b0;
                  state_d  = ST_COMPACT;
                  rd_idx_d = CNT_W'(1);
                  wr_idx_d = '0;
                end
              end
            end
            OP_EXISTS: rsp_d.hit = (cnt_q != '0);
            OP_COUNT:  rsp_d.result_value = DATA_W'(cnt_q);
            default: begin
              if (cnt_q != '0) begin
                // entries before the first match stay in place
                done_d   = 1'b0;
                state_d  = ST_COMPACT;
                rd_idx_d = CNT_W'(first_q);
                wr_idx_d = CNT_W'(first_q);
              end
            end
          endcase
        end
      end

      ST_COMPACT: begin
        if (rd_idx_q < held_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
          tag_d    = rd_idx_q[ADDR_W-1:0];
        end
        if (pend_q && keep) begin
          ram_req_o.we = 1'b1;
          wr_idx_d     = wr_idx_q + 1'b1;
        end
        if (walk_end) begin
          done_d             = 1'b1;
          state_d            = ST_IDLE;
          rsp_d.result_value = '0;
          if (op_q == OP_APPEND || op_q == OP_APPEND_UNIQ) begin
            ram_req_o.we     = 1'b1;
            ram_req_o.wdata  = val_q;
            held_d           = wr_idx_q + 1'b1;
            rsp_d.hit        = (op_q == OP_APPEND_UNIQ);
            rsp_d.fill_count = FILL_W'(wr_idx_q + 1'b1);
          end else begin
            held_d           = wr_idx_q;
            rsp_d.hit        = 1'b1;
            rsp_d.fill_count = FILL_W'(wr_idx_q);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

/* rtl/bounded_history_table_core.sv */
// ----------------------------------------------------------------------------
// bounded_history_table_core
// ordered history of up to history_limit values with search, count, removal
// and a serial counter
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. When it is done,
// done_o is high for exactly one cycle with its result on rsp_o; the receiver
// cannot hold it off, and a new request may be taken in that same cycle. Next
// serial, clear, unknown codes, requests with a zero limit and an append below
// the limit answer on the following cycle. Exists and count walk the held
// entries through the single read port of the store, one per cycle. A remove
// that hits, and an append unique of an absent value into a full table, add a
// second walk that reads and rewrites each kept entry, and an append into a full
// table takes that walk alone. cfg_we_i writes the limit at once; change it only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_history_table_core_macros.svh"

module bounded_history_table_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire bht_pkg::bht_req_t           req_i,
  output logic                             done_o,
  output bht_pkg::bht_rsp_t                rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bht_pkg::LIM_W-1:0]   cfg_data_i
);
  import bht_pkg::*;

  logic [LIM_W-1:0]  limit_q;
  logic [CNT_W-1:0]  limit_eff;
  bht_ram_req_t      ram_req;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // limit saturates at the store depth
  always_comb begin
    if (32'(limit_q) > DEPTH) begin
      limit_eff = CNT_W'(DEPTH);
    end else begin
      limit_eff = CNT_W'(limit_q);
    end
  end

  bht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .limit_i     (limit_eff),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bht_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  `BHT_ASSERT_IMP(a_done_when_idle, done_o, !busy_o, "result shown while busy")
  `BHT_ASSERT_NXT(a_busy_ends_in_result, busy_o, busy_o || done_o, "walk ended without result")
  `BHT_ASSERT_IMP(a_fill_in_range, done_o, 32'(rsp_o.fill_count) <= DEPTH, "fill above depth")
  `BHT_ASSERT_IMP(a_write_owned, ram_req.we, busy_o || start_i, "store written without request")

endmodule

`default_nettype wire
